FILE: hw/rtl/sit_pkg.sv
package sit_pkg;

  // Width of every coordinate field on the input channel
  localparam int FIELD_WIDTH = 32;

  // Default and supported range of the coordinate width actually used
  localparam int COORD_WIDTH_DEF = 32;
  localparam int COORD_WIDTH_MIN = 8;
  localparam int COORD_WIDTH_MAX = 32;

  // Orientation sign of one cross product
  typedef logic [1:0] ori_t;

  localparam ori_t ORI_ZERO = 2'b00;
  localparam ori_t ORI_POS  = 2'b01;
  localparam ori_t ORI_NEG  = 2'b10;

endpackage

FILE: hw/rtl/sit_in_if.sv
interface sit_in_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [sit_pkg::FIELD_WIDTH-1:0] seg_a_start_x;
  logic signed [sit_pkg::FIELD_WIDTH-1:0] seg_a_start_y;
  logic signed [sit_pkg::FIELD_WIDTH-1:0] seg_a_end_x;
  logic signed [sit_pkg::FIELD_WIDTH-1:0] seg_a_end_y;
  logic signed [sit_pkg::FIELD_WIDTH-1:0] seg_b_start_x;
  logic signed [sit_pkg::FIELD_WIDTH-1:0] seg_b_start_y;
  logic signed [sit_pkg::FIELD_WIDTH-1:0] seg_b_end_x;
  logic signed [sit_pkg::FIELD_WIDTH-1:0] seg_b_end_y;

  modport source (
    output valid, seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
           seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y,
    input  ready
  );

  modport sink (
    input  valid, seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
           seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y,
    output ready
  );
endinterface

FILE: hw/rtl/sit_out_if.sv
interface sit_out_if;
  logic valid;
  logic ready;
  logic segments_meet;

  modport source (
    output valid, segments_meet,
    input  ready
  );

  modport sink (
    input  valid, segments_meet,
    output ready
  );
endinterface

FILE: hw/rtl/sit_orient.sv
// Two-stage orientation sign: register both products, then their difference's sign.
module sit_orient #(
  parameter int COORD_WIDTH = sit_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [COORD_WIDTH:0]   qp_x,
  input  logic signed [COORD_WIDTH:0]   qp_y,
  input  logic signed [COORD_WIDTH:0]   rp_x,
  input  logic signed [COORD_WIDTH:0]   rp_y,
  output sit_pkg::ori_t                 ori
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;
  localparam int XW = PW + 1;

  logic signed [PW-1:0] p1_r, p1_nxt;
  logic signed [PW-1:0] p2_r, p2_nxt;
  logic signed [XW-1:0] cross_d;
  sit_pkg::ori_t        ori_r, ori_nxt;

  assign p1_nxt = PW'(qp_x) * PW'(rp_y);
  assign p2_nxt = PW'(qp_y) * PW'(rp_x);

  // exact cross product, one bit wider than either product
  assign cross_d = XW'(p1_r) - XW'(p2_r);

  always_comb begin
    if (cross_d == '0) begin
      ori_nxt = sit_pkg::ORI_ZERO;
    end else if (cross_d[XW-1]) begin
      ori_nxt = sit_pkg::ORI_NEG;
    end else begin
      ori_nxt = sit_pkg::ORI_POS;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r  <= p1_nxt;
      p2_r  <= p2_nxt;
      ori_r <= ori_nxt;
    end
  end

  assign ori = ori_r;

endmodule

FILE: hw/rtl/segment_intersection_test.sv
// Closed line segment intersection test. Each input transaction carries two segments A and
// B as signed integer end points (the low COORD_WIDTH bits of each 32-bit field, sign
// extended) and yields one result transaction: segments_meet is 1 when the segments share
// at least one point, end points and collinear overlap included. The block is a
// four-stage pipeline (coordinate differences and bounding-box compares, the eight
// products of (COORD_WIDTH+1)-bit signed differences, the four cross-product signs, the
// final decision in the output register), and a new pair is accepted every cycle while the
// output is not stalled; the product stage, one multiplier per product, sets the clock. All
// stages hold together while a finished result waits on out_res.ready, so in_seg.ready is
// low only while the output register is full and not being taken. Cross products are
// computed exactly in 2*COORD_WIDTH+3 bits, so no cross product can overflow.
module segment_intersection_test #(
  parameter int COORD_WIDTH = sit_pkg::COORD_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  sit_in_if.sink       in_seg,
  sit_out_if.source    out_res
);

  localparam int CW = COORD_WIDTH;
  localparam int DW = COORD_WIDTH + 1;

  // Difference of two coordinates, one bit wider so it never wraps
  function automatic logic signed [DW-1:0] dif(input logic signed [CW-1:0] a,
                                               input logic signed [CW-1:0] b);
    dif = DW'(a) - DW'(b);
  endfunction

  // Point p inside the inclusive bounding box of s..e
  function automatic logic in_box(input logic signed [CW-1:0] sx, input logic signed [CW-1:0] sy,
                                  input logic signed [CW-1:0] ex, input logic signed [CW-1:0] ey,
                                  input logic signed [CW-1:0] px, input logic signed [CW-1:0] py);
    logic okx;
    logic oky;
    okx = (sx <= px && px <= ex) || (ex <= px && px <= sx);
    oky = (sy <= py && py <= ey) || (ey <= py && py <= sy);
    in_box = okx && oky;
  endfunction

  // Pipeline control: every stage advances when the output register can take a result
  logic advance;
  logic v1_r, v2_r, v3_r, out_valid_r;

  assign advance      = !out_valid_r || out_res.ready;
  assign in_seg.ready = advance;

  // Coordinates, low COORD_WIDTH bits of each field
  logic signed [CW-1:0] asx, asy, aex, aey, bsx, bsy, bex, bey;

  assign asx = in_seg.seg_a_start_x[CW-1:0];
  assign asy = in_seg.seg_a_start_y[CW-1:0];
  assign aex = in_seg.seg_a_end_x[CW-1:0];
  assign aey = in_seg.seg_a_end_y[CW-1:0];
  assign bsx = in_seg.seg_b_start_x[CW-1:0];
  assign bsy = in_seg.seg_b_start_y[CW-1:0];
  assign bex = in_seg.seg_b_end_x[CW-1:0];
  assign bey = in_seg.seg_b_end_y[CW-1:0];

  // Stage 1: operands of the four orientation tests orient(p, q, r), with q-p and r-p.
  // Tests 0,1 take B's end points against line A, tests 2,3 A's end points against line B.
  logic signed [DW-1:0] qp_x_r[4], qp_x_nxt[4];
  logic signed [DW-1:0] qp_y_r[4], qp_y_nxt[4];
  logic signed [DW-1:0] rp_x_r[4], rp_x_nxt[4];
  logic signed [DW-1:0] rp_y_r[4], rp_y_nxt[4];
  logic [3:0]           box1_r, box1_nxt;
  logic [3:0]           box2_r, box3_r;

  always_comb begin
    qp_x_nxt[0] = dif(aex, asx);
    qp_y_nxt[0] = dif(aey, asy);
    rp_x_nxt[0] = dif(bsx, asx);
    rp_y_nxt[0] = dif(bsy, asy);

    qp_x_nxt[1] = dif(aex, asx);
    qp_y_nxt[1] = dif(aey, asy);
    rp_x_nxt[1] = dif(bex, asx);
    rp_y_nxt[1] = dif(bey, asy);

    qp_x_nxt[2] = dif(bex, bsx);
    qp_y_nxt[2] = dif(bey, bsy);
    rp_x_nxt[2] = dif(asx, bsx);
    rp_y_nxt[2] = dif(asy, bsy);

    qp_x_nxt[3] = dif(bex, bsx);
    qp_y_nxt[3] = dif(bey, bsy);
    rp_x_nxt[3] = dif(aex, bsx);
    rp_y_nxt[3] = dif(aey, bsy);

    // the box checks pair with the tests above: the tested point in the other box
    box1_nxt[0] = in_box(asx, asy, aex, aey, bsx, bsy);
    box1_nxt[1] = in_box(asx, asy, aex, aey, bex, bey);
    box1_nxt[2] = in_box(bsx, bsy, bex, bey, asx, asy);
    box1_nxt[3] = in_box(bsx, bsy, bex, bey, aex, aey);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      qp_x_r <= qp_x_nxt;
      qp_y_r <= qp_y_nxt;
      rp_x_r <= rp_x_nxt;
      rp_y_r <= rp_y_nxt;
      box1_r <= box1_nxt;
      box2_r <= box1_r;
      box3_r <= box2_r;
    end
  end

  // Stages 2 and 3: products, then cross-product sign, inside each orientation unit
  sit_pkg::ori_t ori[4];

  for (genvar g = 0; g < 4; g++) begin : g_orient
    sit_orient #(
      .COORD_WIDTH (COORD_WIDTH)
    ) u_orient (
      .clk  (clk),
      .en   (advance),
      .qp_x (qp_x_r[g]),
      .qp_y (qp_y_r[g]),
      .rp_x (rp_x_r[g]),
      .rp_y (rp_y_r[g]),
      .ori  (ori[g])
    );
  end

  // Stage 4: proper crossing, or a collinear end point inside the other segment's box
  logic meet_r, meet_nxt;

  always_comb begin
    meet_nxt = (ori[0] != ori[1] && ori[2] != ori[3])
            || (ori[0] == sit_pkg::ORI_ZERO && box3_r[0])
            || (ori[1] == sit_pkg::ORI_ZERO && box3_r[1])
            || (ori[2] == sit_pkg::ORI_ZERO && box3_r[2])
            || (ori[3] == sit_pkg::ORI_ZERO && box3_r[3]);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      meet_r <= meet_nxt;
    end
  end

  // Valid bits travel with the data; hold all of them on a stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      v1_r        <= in_seg.valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  assign out_res.valid         = out_valid_r;
  assign out_res.segments_meet = meet_r;

  // An accepted transaction always lands in the first stage
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_seg.valid && in_seg.ready) |=> v1_r)
    else $error("accepted transaction missing from stage 1");

  // A stall freezes the valid bits and the stage-1 box flags
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable({v1_r, v2_r, v3_r, out_valid_r}) && $stable(box1_r))
    else $error("pipeline moved during a stall");

  // The last compute stage always reaches the output register when it advances
  a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && advance) |=> out_valid_r)
    else $error("result dropped before the output register");

endmodule
